/* sv/arsf_pkg.sv */
package arsf_pkg;

    // Register indexes on the configuration channel
    localparam logic [1:0] CFG_ADDR_FILTER_EN = 2'd0;
    localparam logic [1:0] CFG_PEER_ADDRESS   = 2'd1;
    localparam logic [1:0] CFG_TARGET_UUID    = 2'd2;

    localparam logic [15:0] TARGET_UUID_RESET = 16'hABF2;

    // Advertising data structure types holding 16-bit UUID lists
    localparam logic [7:0] AD_UUID16_PARTIAL  = 8'h02;
    localparam logic [7:0] AD_UUID16_COMPLETE = 8'h03;

    // Legacy event types that allow a connection
    localparam logic [2:0] EVT_ADV_IND        = 3'd0;
    localparam logic [2:0] EVT_ADV_DIRECT_IND = 3'd1;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_DATA   = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_MATCH         = 2'd0,
        VERDICT_BAD_EVENT     = 2'd1,
        VERDICT_ADDR_MISMATCH = 2'd2,
        VERDICT_UUID_ABSENT   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic        mode;
        logic [2:0]  event_type;
        logic [47:0] address;
        logic [7:0]  data_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic     connect;
        verdict_t verdict;
    } result_t;

endpackage

/* sv/arsf_in_stage.sv */
module arsf_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  arsf_pkg::item_t in_item,
    output logic            item_valid,
    input  logic            item_take,
    output arsf_pkg::item_t item
);

    logic            valid_reg;
    arsf_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* sv/arsf_walker.sv */
module arsf_walker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [47:0]       cfg_data,
    input  logic              step,
    input  arsf_pkg::item_t   item,
    output logic              result_valid,
    output arsf_pkg::result_t result
);

    logic        addr_en_reg;
    logic [47:0] peer_addr_reg;
    logic [15:0] uuid_reg;

    logic [7:0]  pos_reg,     pos_next;
    logic [7:0]  len_reg,     len_next;
    logic [7:0]  start_reg,   start_next;
    logic [7:0]  slen_reg,    slen_next;
    logic [7:0]  kind_reg,    kind_next;
    logic [7:0]  prev_reg,    prev_next;
    logic        stopped_reg, stopped_next;
    logic        seen_reg,    seen_next;
    logic [1:0]  hres_reg,    hres_next;
    logic        active_reg,  active_next;

    logic [7:0]  rel;
    logic [9:0]  struct_end;
    logic        emit;
    arsf_pkg::verdict_t verdict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_en_reg   <= 1'b0;
            peer_addr_reg <= '0;
            uuid_reg      <= arsf_pkg::TARGET_UUID_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                arsf_pkg::CFG_ADDR_FILTER_EN: addr_en_reg   <= cfg_data[0];
                arsf_pkg::CFG_PEER_ADDRESS:   peer_addr_reg <= cfg_data;
                arsf_pkg::CFG_TARGET_UUID:    uuid_reg      <= cfg_data[15:0];
                default:                      ;
            endcase
        end
    end

    assign rel        = pos_reg - start_reg;
    assign struct_end = {2'b00, start_reg} + {2'b00, item.data_byte} + 10'd1;

    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        start_next   = start_reg;
        slen_next    = slen_reg;
        kind_next    = kind_reg;
        prev_next    = prev_reg;
        stopped_next = stopped_reg;
        seen_next    = seen_reg;
        hres_next    = hres_reg;
        active_next  = active_reg;
        emit         = 1'b0;

        if (step)
        begin
            if (item.mode == arsf_pkg::MODE_HEADER)
            begin
                if (item.event_type != arsf_pkg::EVT_ADV_IND &&
                    item.event_type != arsf_pkg::EVT_ADV_DIRECT_IND)
                begin
                    hres_next = arsf_pkg::VERDICT_BAD_EVENT;
                end
                else if (addr_en_reg && item.address != peer_addr_reg)
                begin
                    hres_next = arsf_pkg::VERDICT_ADDR_MISMATCH;
                end
                else
                begin
                    hres_next = arsf_pkg::VERDICT_MATCH;
                end
                len_next     = item.data_length;
                pos_next     = '0;
                start_next   = '0;
                slen_next    = '0;
                kind_next    = '0;
                prev_next    = '0;
                stopped_next = 1'b0;
                seen_next    = 1'b0;
                active_next  = 1'b1;
                emit         = (item.data_length == 8'd0);
            end
            else if (active_reg)
            begin
                if (!stopped_reg && !seen_reg)
                begin
                    if (rel == 8'd0)
                    begin
                        // Zero length or overrun ends the structure walk
                        if (item.data_byte == 8'd0 || struct_end > {2'b00, len_reg})
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            slen_next = item.data_byte;
                        end
                    end
                    else
                    begin
                        if (rel == 8'd1)
                        begin
                            kind_next = item.data_byte;
                        end
                        else if (rel[0] && rel >= 8'd3 &&
                                 (kind_reg == arsf_pkg::AD_UUID16_PARTIAL ||
                                  kind_reg == arsf_pkg::AD_UUID16_COMPLETE))
                        begin
                            if (prev_reg == uuid_reg[7:0] && item.data_byte == uuid_reg[15:8])
                            begin
                                seen_next = 1'b1;
                            end
                        end
                        if (rel == slen_reg)
                        begin
                            start_next = pos_reg + 8'd1;
                        end
                    end
                end
                prev_next = item.data_byte;
                pos_next  = pos_reg + 8'd1;
                emit      = (pos_next >= len_reg);
            end
        end

        if (emit)
        begin
            active_next = 1'b0;
        end
    end

    always_comb
    begin
        if (hres_next != arsf_pkg::VERDICT_MATCH)
        begin
            verdict = arsf_pkg::verdict_t'(hres_next);
        end
        else if (seen_next)
        begin
            verdict = arsf_pkg::VERDICT_MATCH;
        end
        else
        begin
            verdict = arsf_pkg::VERDICT_UUID_ABSENT;
        end
    end

    assign result_valid   = emit;
    assign result.verdict = verdict;
    assign result.connect = (verdict == arsf_pkg::VERDICT_MATCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            start_reg   <= '0;
            slen_reg    <= '0;
            kind_reg    <= '0;
            prev_reg    <= '0;
            stopped_reg <= 1'b0;
            seen_reg    <= 1'b0;
            hres_reg    <= '0;
            active_reg  <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            start_reg   <= start_next;
            slen_reg    <= slen_next;
            kind_reg    <= kind_next;
            prev_reg    <= prev_next;
            stopped_reg <= stopped_next;
            seen_reg    <= seen_next;
            hres_reg    <= hres_next;
            active_reg  <= active_next;
        end
    end

endmodule

/* sv/arsf_out_stage.sv */
module arsf_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              result_valid,
    input  arsf_pkg::result_t result,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output arsf_pkg::result_t out_result
);

    logic              valid_reg;
    arsf_pkg::result_t result_reg;

    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= result_valid;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result_valid)
        begin
            result_reg <= result;
        end
    end

endmodule

/* sv/adv_report_service_filter.sv */
// Channel  Group                          Payload (low bit first)
// -------  -----------------------------  ---------------------------------------------
// in       s_axis_tvalid/tready/tdata/tuser  tdata: event_type, address, data_length,
//                                            data_byte; tuser: mode
// out      m_axis_tvalid/tready/tdata        tdata: connect, verdict
// cfg      cfg_valid/cfg_ready               cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an item waits in the input
// register for the walker step, which registers its verdict (if any) for the output.
// Rate is set by the single walker step between the input and result registers.
// Reset (rst_n low) clears all report state and loads the register defaults.
// A stalled output holds the walker and, through it, the input register.
module adv_report_service_filter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // event_type[2:0], address[50:3], data_length[58:51],
                                        // data_byte[66:59], zero fill
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // connect[0], verdict[2:1], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    arsf_pkg::item_t   in_item;
    arsf_pkg::item_t   item;
    arsf_pkg::result_t result;
    arsf_pkg::result_t out_result;
    logic              item_valid;
    logic              out_free;
    logic              step;
    logic              result_valid;

    assign in_item.mode        = s_axis_tuser;
    assign in_item.event_type  = s_axis_tdata[2:0];
    assign in_item.address     = s_axis_tdata[50:3];
    assign in_item.data_length = s_axis_tdata[58:51];
    assign in_item.data_byte   = s_axis_tdata[66:59];

    assign cfg_ready = 1'b1;

    // Advance the walker only when the result register can take its output
    assign step = item_valid && out_free;

    arsf_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (step),
        .item       (item)
    );

    arsf_walker u_walker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (step),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    arsf_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step),
        .result_valid (result_valid),
        .result       (result),
        .free         (out_free),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_result   (out_result)
    );

    assign m_axis_tdata = {5'b00000, out_result.verdict, out_result.connect};

endmodule

/* test/tb_adv_report_service_filter.sv */
module tb_adv_report_service_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic               connect;
        arsf_pkg::verdict_t verdict;
    } verdict_rec_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = arsf_pkg::MODE_HEADER;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = arsf_pkg::CFG_ADDR_FILTER_EN;
    logic [47:0] cfg_data      = '0;

    adv_report_service_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the filter registers
    logic        shadow_addr_en = 1'b0;
    logic [47:0] shadow_peer    = '0;
    logic [15:0] shadow_uuid    = arsf_pkg::TARGET_UUID_RESET;

    // Shadow copy of the report walker
    logic [7:0]  rpt_pos     = '0;
    logic [7:0]  rpt_len     = '0;
    logic [7:0]  ad_start    = '0;
    logic [7:0]  ad_len      = '0;
    logic [7:0]  ad_kind     = '0;
    logic [7:0]  last_byte   = '0;
    logic        walk_done   = 1'b0;
    logic        uuid_found  = 1'b0;
    arsf_pkg::verdict_t hdr_verdict = arsf_pkg::VERDICT_MATCH;
    logic        rpt_active  = 1'b0;

    verdict_rec_t verdict_q[$];
    logic [7:0]   ad_bytes[$];

    int error_count    = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;
    int rx_hold_request = 0;
    bit tx_idle_on     = 1'b1;
    bit rx_idle_on     = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(string what, int want_v, int got_v);
        $display("mismatch at %0t: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [47:0] rand48();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom();
        lo = $urandom();
        return {hi[15:0], lo};
    endfunction

    function automatic logic [2:0] pick_event();
        logic [2:0] ev;
        if ($urandom_range(0, 3) != 0)
            ev = 3'($urandom_range(0, 1));
        else
            ev = 3'($urandom_range(0, 7));
        return ev;
    endfunction

    function automatic logic [47:0] pick_address();
        int r;
        logic [47:0] a;
        r = $urandom_range(0, 99);
        if (r < 70)
            a = shadow_peer;
        else if (r < 85)
            a = shadow_peer ^ (48'd1 << $urandom_range(0, 47));
        else
            a = rand48();
        return a;
    endfunction

    function automatic void post_verdict();
        verdict_rec_t rec;
        if (hdr_verdict != arsf_pkg::VERDICT_MATCH)
            rec.verdict = hdr_verdict;
        else
            rec.verdict = uuid_found ? arsf_pkg::VERDICT_MATCH : arsf_pkg::VERDICT_UUID_ABSENT;
        rec.connect = (rec.verdict == arsf_pkg::VERDICT_MATCH);
        verdict_q.push_back(rec);
        rpt_active = 1'b0;
    endfunction

    // Advance the shadow walker by one accepted item and queue its verdict, if any
    function automatic void filter_step(logic mode, logic [2:0] ev, logic [47:0] addr,
                                        logic [7:0] len, logic [7:0] b);
        logic [7:0] rel;
        int         reach;
        if (mode == arsf_pkg::MODE_HEADER)
        begin
            if (ev != arsf_pkg::EVT_ADV_IND && ev != arsf_pkg::EVT_ADV_DIRECT_IND)
                hdr_verdict = arsf_pkg::VERDICT_BAD_EVENT;
            else if (shadow_addr_en && addr != shadow_peer)
                hdr_verdict = arsf_pkg::VERDICT_ADDR_MISMATCH;
            else
                hdr_verdict = arsf_pkg::VERDICT_MATCH;
            rpt_len    = len;
            rpt_pos    = '0;
            ad_start   = '0;
            ad_len     = '0;
            ad_kind    = '0;
            last_byte  = '0;
            walk_done  = 1'b0;
            uuid_found = 1'b0;
            rpt_active = 1'b1;
            if (len == 0)
                post_verdict();
        end
        else if (rpt_active)
        begin
            if (!walk_done && !uuid_found)
            begin
                rel   = rpt_pos - ad_start;
                reach = ad_start + b + 1;
                if (rel == 0 && (b == 0 || reach > rpt_len))
                    walk_done = 1'b1;
                else
                begin
                    if (rel == 0)
                        ad_len = b;
                    else if (rel == 1)
                        ad_kind = b;
                    else if (rel[0] && rel >= 3 &&
                             (ad_kind == arsf_pkg::AD_UUID16_PARTIAL ||
                              ad_kind == arsf_pkg::AD_UUID16_COMPLETE) &&
                             last_byte == shadow_uuid[7:0] && b == shadow_uuid[15:8])
                        uuid_found = 1'b1;
                    if (rel == ad_len)
                        ad_start = rpt_pos + 8'd1;
                end
            end
            last_byte = b;
            rpt_pos   = rpt_pos + 8'd1;
            if (rpt_pos >= rpt_len)
                post_verdict();
        end
    endfunction

    // Offer one item; valid stays high on return so a back-to-back item needs no gap
    task automatic send_item(logic mode, logic [2:0] ev, logic [47:0] addr,
                             logic [7:0] len, logic [7:0] b);
        int g;
        g = tx_idle_on ? pick_gap() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {5'b0, b, len, addr, ev};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (mode == arsf_pkg::MODE_HEADER || rpt_active)
            items_sent++;
        filter_step(mode, ev, addr, len, b);
    endtask

    task automatic send_header(logic [2:0] ev, logic [47:0] addr, logic [7:0] len);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_item(arsf_pkg::MODE_HEADER, ev, addr, len, junk);
    endtask

    task automatic send_data(logic [7:0] b);
        logic [2:0] junk_ev;
        logic [7:0] junk_len;
        junk_ev  = 3'($urandom_range(0, 7));
        junk_len = 8'($urandom_range(0, 255));
        send_item(arsf_pkg::MODE_DATA, junk_ev, rand48(), junk_len, b);
    endtask

    task automatic send_report(logic [2:0] ev, logic [47:0] addr);
        send_header(ev, addr, 8'(ad_bytes.size()));
        foreach (ad_bytes[k])
            send_data(ad_bytes[k]);
    endtask

    // Lower valid, then hold until every queued verdict has come out
    task automatic wait_for_verdicts();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    task automatic load_settings(logic en, logic [47:0] peer, logic [15:0] uuid);
        logic [1:0] reg_idx;
        wait_for_verdicts();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int k = 0; k < 3; k++)
        begin
            reg_idx = 2'(k);
            case (reg_idx)
                arsf_pkg::CFG_ADDR_FILTER_EN: cfg_data <= {47'b0, en};
                arsf_pkg::CFG_PEER_ADDRESS:   cfg_data <= peer;
                default:                      cfg_data <= {32'b0, uuid};
            endcase
            cfg_index <= reg_idx;
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (reg_idx)
                arsf_pkg::CFG_ADDR_FILTER_EN: shadow_addr_en = en;
                arsf_pkg::CFG_PEER_ADDRESS:   shadow_peer    = peer;
                default:                      shadow_uuid    = uuid;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Fill ad_bytes with a length-type-value walk, planting the target UUID now and then
    task automatic build_adv_data(int max_len, bit plant);
        int room;
        int r;
        int npairs;
        int odd;
        int n;
        int reach;
        logic [7:0] lb;
        ad_bytes.delete();
        while (ad_bytes.size() < max_len)
        begin
            room = max_len - ad_bytes.size();
            r    = $urandom_range(0, 99);
            if (room < 2)
            begin
                lb = 8'($urandom_range(0, 255));
                ad_bytes.push_back(lb);
            end
            else if (r < 4)
            begin
                // zero length ends the walk; pad with noise
                ad_bytes.push_back(8'h00);
                while (ad_bytes.size() < max_len)
                begin
                    lb = 8'($urandom_range(0, 255));
                    ad_bytes.push_back(lb);
                end
            end
            else if (r < 10)
            begin
                // length runs past the end of the data
                reach = room + $urandom_range(0, 3);
                lb    = (reach > 255) ? 8'hFF : 8'(reach);
                ad_bytes.push_back(lb);
                while (ad_bytes.size() < max_len)
                begin
                    lb = 8'($urandom_range(0, 255));
                    ad_bytes.push_back(lb);
                end
            end
            else if (r < 65)
            begin
                npairs = $urandom_range(0, ((room - 2) / 2 < 4) ? (room - 2) / 2 : 4);
                odd    = (room - 2 > 2 * npairs) ? $urandom_range(0, 1) : 0;
                lb     = 8'(1 + 2 * npairs + odd);
                ad_bytes.push_back(lb);
                ad_bytes.push_back(r < 38 ? arsf_pkg::AD_UUID16_PARTIAL :
                                            arsf_pkg::AD_UUID16_COMPLETE);
                for (int k = 0; k < npairs; k++)
                begin
                    if (plant && $urandom_range(0, 2) == 0)
                    begin
                        ad_bytes.push_back(shadow_uuid[7:0]);
                        ad_bytes.push_back(shadow_uuid[15:8]);
                    end
                    else
                    begin
                        lb = 8'($urandom_range(0, 255));
                        ad_bytes.push_back(lb);
                        lb = 8'($urandom_range(0, 255));
                        ad_bytes.push_back(lb);
                    end
                end
                if (odd != 0)
                begin
                    lb = $urandom_range(0, 1) ? shadow_uuid[7:0] : 8'($urandom_range(0, 255));
                    ad_bytes.push_back(lb);
                end
            end
            else
            begin
                n  = $urandom_range(0, (room - 2 < 8) ? room - 2 : 8);
                lb = 8'(n + 1);
                ad_bytes.push_back(lb);
                repeat (n + 1)
                begin
                    lb = 8'($urandom_range(0, 255));
                    ad_bytes.push_back(lb);
                end
            end
        end
    endtask

    task automatic run_random_reports(int n_items);
        int goal;
        int r;
        int k;
        int cut;
        logic [7:0] lb;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                k = $urandom_range(0, 99);
                build_adv_data(k < 94 ? $urandom_range(0, 31) :
                               (k < 99 ? $urandom_range(32, 80) : $urandom_range(200, 255)),
                               $urandom_range(0, 9) < 6);
                send_report(pick_event(), pick_address());
            end
            else if (r < 80)
            begin
                ad_bytes.delete();
                repeat ($urandom_range(0, 31))
                begin
                    lb = 8'($urandom_range(0, 255));
                    ad_bytes.push_back(lb);
                end
                send_report(pick_event(), pick_address());
            end
            else if (r < 88)
            begin
                // cut the report short; the next header drops it
                build_adv_data($urandom_range(1, 31), 1'b1);
                cut = $urandom_range(0, ad_bytes.size() - 1);
                send_header(pick_event(), pick_address(), 8'(ad_bytes.size()));
                for (k = 0; k < cut; k++)
                    send_data(ad_bytes[k]);
            end
            else if (r < 93)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    lb = 8'($urandom_range(0, 255));
                    send_data(lb);
                end
            end
            else if (r < 95)
                wait_for_verdicts();
            else
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Runs on reset register values
    task automatic test_directed_cases();
        ad_bytes.delete();
        send_report(arsf_pkg::EVT_ADV_IND, 48'h0);
        ad_bytes = '{arsf_pkg::AD_UUID16_COMPLETE, arsf_pkg::AD_UUID16_COMPLETE,
                     shadow_uuid[7:0], shadow_uuid[15:8]};
        send_report(arsf_pkg::EVT_ADV_DIRECT_IND, 48'hFFFF_FFFF_FFFF);
        // data with no open report
        send_data(8'hFF);
        // odd trailing byte, then target high byte as an overrunning length
        ad_bytes = '{8'h04, arsf_pkg::AD_UUID16_COMPLETE, 8'h11, 8'h22,
                     shadow_uuid[7:0], shadow_uuid[15:8]};
        send_report(arsf_pkg::EVT_ADV_IND, 48'h0);
        ad_bytes = '{8'h00, shadow_uuid[7:0], shadow_uuid[15:8]};
        send_report(arsf_pkg::EVT_ADV_IND, 48'h0);
        ad_bytes = '{8'h05, arsf_pkg::AD_UUID16_PARTIAL, shadow_uuid[7:0], shadow_uuid[15:8]};
        send_report(arsf_pkg::EVT_ADV_IND, 48'h0);
        // new header abandons the open report
        send_header(arsf_pkg::EVT_ADV_IND, 48'h0, 8'd3);
        send_data(arsf_pkg::AD_UUID16_PARTIAL);
        send_header(arsf_pkg::EVT_ADV_DIRECT_IND, 48'h0, 8'd0);
        wait_for_verdicts();
    endtask

    task automatic test_address_filter();
        logic [47:0] peer;
        peer = rand48();
        load_settings(1'b1, peer, 16'($urandom_range(0, 65535)));
        ad_bytes = '{8'h03, arsf_pkg::AD_UUID16_COMPLETE, shadow_uuid[7:0], shadow_uuid[15:8]};
        send_report(arsf_pkg::EVT_ADV_IND, peer);
        send_report(arsf_pkg::EVT_ADV_IND, peer ^ 48'd1);
        send_report(3'd7, peer);
        send_header(3'd5, ~peer, 8'd0);
        send_header(arsf_pkg::EVT_ADV_DIRECT_IND, peer ^ (48'd1 << 47), 8'd0);
        send_header(arsf_pkg::EVT_ADV_IND, peer, 8'd0);
        load_settings(1'b0, peer, shadow_uuid);
        send_report(arsf_pkg::EVT_ADV_DIRECT_IND, ~peer);
        wait_for_verdicts();
    endtask

    task automatic test_config_sweep();
        load_settings(1'b0, 48'h0, 16'h0000);
        run_random_reports(120);
        load_settings(1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        build_adv_data(255, 1'b1);
        send_report(arsf_pkg::EVT_ADV_IND, shadow_peer);
        run_random_reports(120);
        load_settings(1'b1, 48'h0, arsf_pkg::TARGET_UUID_RESET);
        run_random_reports(120);
        load_settings(1'b0, 48'hFFFF_FFFF_FFFF, 16'h0000);
        run_random_reports(120);
    endtask

    // Receiver holds off while the sender streams without gaps
    task automatic test_output_backpressure();
        load_settings(1'b0, rand48(), 16'($urandom_range(0, 65535)));
        tx_idle_on = 1'b0;
        rx_hold_request = HOLD_OFF_CYCLES;
        repeat (4)
        begin
            build_adv_data($urandom_range(8, 16), 1'b1);
            send_report(pick_event(), pick_address());
        end
        tx_idle_on = 1'b1;
        wait_for_verdicts();
    endtask

    task automatic test_sender_pause();
        repeat (6)
        begin
            build_adv_data($urandom_range(0, 8), 1'b1);
            send_report(pick_event(), pick_address());
            wait_for_verdicts();
        end
    endtask

    task automatic test_random_traffic();
        repeat (4)
        begin
            load_settings(1'($urandom_range(0, 1)), rand48(), 16'($urandom_range(0, 65535)));
            run_random_reports(125);
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        int stall_left;
        int g;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_request > 0)
            begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                g = rx_idle_on ? pick_gap() : 0;
                if (g > 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left = g - 1;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        verdict_rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("verdict with none pending", -1, m_axis_tdata);
            else
            begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.connect)
                    report_mismatch("connect", want.connect, m_axis_tdata[0]);
                if (m_axis_tdata[2:1] !== want.verdict)
                    report_mismatch("verdict", want.verdict, m_axis_tdata[2:1]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_adv_report_service_filter: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_address_filter();
        test_config_sweep();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_for_verdicts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdict_q.size() != 0)
            report_mismatch("verdicts left pending", 0, verdict_q.size());
        if (error_count == 0)
            $display("tb_adv_report_service_filter: PASS");
        else
            $display("tb_adv_report_service_filter: FAIL");
        $finish;
    end

endmodule
